[rtl/page_frame_allocator_refcount_unit_macros.svh]
// ---------------------------------------------------------------------------
// page frame allocator assertion macros
// shared property templates for the allocator checks
// ---------------------------------------------------------------------------
`ifndef PAGE_FRAME_ALLOCATOR_REFCOUNT_UNIT_MACROS_SVH
`define PAGE_FRAME_ALLOCATOR_REFCOUNT_UNIT_MACROS_SVH

// same-cycle implication
`define PFA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfa check failed");

// next-cycle implication
`define PFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfa check failed");

`endif

[rtl/pfa_pkg.sv]
// ---------------------------------------------------------------------------
// page frame allocator package
// command and status codes, field widths and parameter defaults
// ---------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

  localparam int PFA_NUM_FRAMES_DEF = 65536;
  localparam int PFA_SHARERS_DEF    = 64;

  localparam int CMD_W    = 4;
  localparam int FRAME_W  = 16;
  localparam int CNT_W    = 8;
  localparam int SH_W     = 6;
  localparam int MAP_W    = 64;
  localparam int STATUS_W = 2;
  localparam int FREE_W   = 17;
  localparam int IN_W     = 96;
  localparam int OUT_W    = 112;

  // largest frame number the frame field can carry, plus one
  localparam int FRAME_SPACE = 65536;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 4'd0;
  localparam logic [CMD_W-1:0] CMD_FREE    = 4'd1;
  localparam logic [CMD_W-1:0] CMD_GET_CNT = 4'd2;
  localparam logic [CMD_W-1:0] CMD_SET_CNT = 4'd3;
  localparam logic [CMD_W-1:0] CMD_INC     = 4'd4;
  localparam logic [CMD_W-1:0] CMD_DEC     = 4'd5;
  localparam logic [CMD_W-1:0] CMD_GET_BIT = 4'd6;
  localparam logic [CMD_W-1:0] CMD_SET_BIT = 4'd7;
  localparam logic [CMD_W-1:0] CMD_GET_MAP = 4'd8;
  localparam logic [CMD_W-1:0] CMD_SET_MAP = 4'd9;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

endpackage

`default_nettype wire

[rtl/page_frame_allocator_refcount_unit.sv]
// ---------------------------------------------------------------------------
// page frame allocator with reference counts
// lifo free stack, per-frame reference count and sharer bitmap tables
// ---------------------------------------------------------------------------
// After reset the block clears all min(NUM_FRAMES, 65536) entries of the
// count and bitmap tables (65536 by default), one entry per cycle, and holds
// s_axis_tready low; configuration writes are taken throughout. Then each
// command passes through the synchronous table read and then the update,
// write-back and result register. Allocate first reads the popped frame
// number from the stack memory, before the tables can be read at it; an
// empty-pool allocate skips that stack read. The result waits in an output
// register; the next command is accepted while it waits, and its update
// stalls only if the previous result has still not been taken.
`default_nettype none

module page_frame_allocator_refcount_unit #(
  parameter int NUM_FRAMES = pfa_pkg::PFA_NUM_FRAMES_DEF,
  parameter int SHARERS    = pfa_pkg::PFA_SHARERS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [pfa_pkg::FRAME_W-1:0] cfg_wdata,
  input  wire logic                       s_axis_tvalid,
  output      logic                       s_axis_tready,
  // frame[15:0], count_value[23:16], sharer[29:24], bit_value[30],
  // bitmap_value[94:31], zero[95]
  input  wire logic [pfa_pkg::IN_W-1:0]    s_axis_tdata,
  // cmd[3:0]
  input  wire logic [pfa_pkg::CMD_W-1:0]   s_axis_tuser,
  output      logic                       m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // out_frame[15:0], refcnt[23:16], bit_res[24], bitmap[88:25],
  // free_count[105:89], zero[111:106]
  output      logic [pfa_pkg::OUT_W-1:0]   m_axis_tdata,
  // status[1:0]
  output      logic [pfa_pkg::STATUS_W-1:0] m_axis_tuser
);

  import pfa_pkg::*;

  localparam int MEM_DEPTH = (NUM_FRAMES < FRAME_SPACE) ? NUM_FRAMES : FRAME_SPACE;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int SAW       = $clog2(NUM_FRAMES);
  localparam int TW        = $clog2(NUM_FRAMES + 1);

  typedef logic [SHARERS-1:0] smap_t;

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;
  localparam logic [1:0] S_EX   = 2'd3;

  logic [1:0]          state;
  logic [AW-1:0]       clr_addr;
  logic [FRAME_W-1:0]  first_usable;
  logic [TW-1:0]       free_top;
  logic [TW-1:0]       free_top_next;

  logic [CMD_W-1:0]    cmd_r;
  logic [FRAME_W-1:0]  frame_r;
  logic [CNT_W-1:0]    cval_r;
  logic [SH_W-1:0]     sh_r;
  logic                bval_r;
  logic [MAP_W-1:0]    bmap_r;
  logic                empty_r;

  logic [FRAME_W-1:0]  stk_mem [0:NUM_FRAMES-1];
  logic [FRAME_W-1:0]  stk_q;
  logic [CNT_W-1:0]    cnt_mem [0:MEM_DEPTH-1];
  logic [CNT_W-1:0]    cnt_q;
  smap_t               map_mem [0:MEM_DEPTH-1];
  smap_t               map_q;

  logic                in_xfer;
  logic                ex_go;
  logic [AW-1:0]       tbl_raddr;
  logic                tbl_rd;
  logic [AW-1:0]       tbl_waddr;
  logic                tbl_we;
  logic [CNT_W-1:0]    tbl_wcnt;
  smap_t               tbl_wmap;

  logic                valid;
  logic [CNT_W-1:0]    cnt_new;
  smap_t               map_new;
  smap_t               sh_mask;
  logic                bit_new;
  logic                push;
  logic [FREE_W-1:0]   free_out;

  logic [STATUS_W-1:0] out_status;
  logic [FRAME_W-1:0]  out_frame;
  logic [CNT_W-1:0]    out_cnt;
  logic                out_bit;
  logic [MAP_W-1:0]    out_map;
  logic [FREE_W-1:0]   out_free;

  assign s_axis_tready = (state == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign ex_go         = (state == S_EX) && (!m_axis_tvalid || m_axis_tready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(MEM_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            if (s_axis_tuser == CMD_ALLOC && free_top != '0) begin
              state <= S_POP;
            end else begin
              state <= S_EX;
            end
          end
        end
        S_POP: begin
          state <= S_EX;
        end
        S_EX: begin
          if (ex_go) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_usable <= '0;
    end else if (cfg_we) begin
      first_usable <= cfg_wdata;
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r   <= s_axis_tuser;
      frame_r <= s_axis_tdata[15:0];
      cval_r  <= s_axis_tdata[23:16];
      sh_r    <= s_axis_tdata[29:24];
      bval_r  <= s_axis_tdata[30];
      bmap_r  <= s_axis_tdata[94:31];
      empty_r <= (s_axis_tuser == CMD_ALLOC) && (free_top == '0);
    end else if (state == S_POP) begin
      frame_r <= stk_q;
    end
  end

  // free stack
  always_ff @(posedge clk) begin
    if (push) begin
      stk_mem[free_top[SAW-1:0]] <= frame_r;
    end
    if (state == S_IDLE) begin
      stk_q <= stk_mem[free_top_next[SAW-1:0] - SAW'(1)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_top <= '0;
    end else if (ex_go) begin
      free_top <= free_top_next;
    end
  end

  // count and bitmap tables
  assign tbl_rd    = (state == S_IDLE) || (state == S_POP);
  assign tbl_raddr = (state == S_POP) ? stk_q[AW-1:0] : s_axis_tdata[AW-1:0];
  assign tbl_we    = (state == S_CLR) || (ex_go && valid && !empty_r);
  assign tbl_waddr = (state == S_CLR) ? clr_addr : frame_r[AW-1:0];
  assign tbl_wcnt  = (state == S_CLR) ? '0 : cnt_new;
  assign tbl_wmap  = (state == S_CLR) ? '0 : map_new;

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      cnt_mem[tbl_waddr] <= tbl_wcnt;
      map_mem[tbl_waddr] <= tbl_wmap;
    end
    if (tbl_rd) begin
      cnt_q <= cnt_mem[tbl_raddr];
      map_q <= map_mem[tbl_raddr];
    end
  end

  // update
  assign sh_mask = smap_t'(64'd1 << sh_r);

  always_comb begin
    valid = (32'(frame_r) < NUM_FRAMES);
    if (cmd_r == CMD_FREE && frame_r < first_usable) begin
      valid = 1'b0;
    end
    cnt_new = cnt_q;
    map_new = map_q;
    bit_new = 1'b0;
    unique case (cmd_r)
      CMD_ALLOC: cnt_new = CNT_W'(1);
      CMD_FREE, CMD_DEC: begin
        if (cnt_q != '0) begin
          cnt_new = cnt_q - CNT_W'(1);
        end
      end
      CMD_SET_CNT: cnt_new = cval_r;
      CMD_INC: begin
        if (cnt_q != CNT_MAX) begin
          cnt_new = cnt_q + CNT_W'(1);
        end
      end
      CMD_GET_BIT: bit_new = |(map_q & sh_mask);
      CMD_SET_BIT: map_new = bval_r ? (map_q | sh_mask) : (map_q & ~sh_mask);
      CMD_SET_MAP: map_new = bmap_r[SHARERS-1:0];
      default: begin
      end
    endcase
  end

  assign push = ex_go && valid && (cmd_r == CMD_FREE) && (cnt_new == '0)
                && (32'(free_top) < NUM_FRAMES);

  always_comb begin
    free_top_next = free_top;
    if (state == S_EX) begin
      if (cmd_r == CMD_ALLOC && !empty_r) begin
        free_top_next = free_top - TW'(1);
      end else if (push) begin
        free_top_next = free_top + TW'(1);
      end
    end
  end

  generate
    if (TW >= FREE_W) begin : g_free_trunc
      assign free_out = free_top_next[FREE_W-1:0];
    end else begin : g_free_ext
      assign free_out = {{(FREE_W - TW){1'b0}}, free_top_next};
    end
  endgenerate

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ex_go) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_go) begin
      out_free <= free_out;
      if (empty_r) begin
        out_status <= ST_EMPTY;
        out_frame  <= '0;
        out_cnt    <= '0;
        out_bit    <= 1'b0;
        out_map    <= '0;
      end else begin
        out_status <= valid ? ST_OK : ST_RANGE;
        out_frame  <= frame_r;
        out_cnt    <= valid ? cnt_new : '0;
        out_bit    <= valid && bit_new;
        out_map    <= valid ? MAP_W'(map_new) : '0;
      end
    end
  end

  assign m_axis_tdata = {6'd0, out_free, out_map, out_bit, out_cnt, out_frame};
  assign m_axis_tuser = out_status;

  // checks
  `include "page_frame_allocator_refcount_unit_macros.svh"

  `PFA_ASSERT_NEXT(a_busy_after_xfer, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `PFA_ASSERT_IMPL(a_top_bound, 1'b1, 32'(free_top) <= NUM_FRAMES)
  `PFA_ASSERT_IMPL(a_result_from_ex, $rose(m_axis_tvalid), $past(state) == S_EX)
  `PFA_ASSERT_IMPL(a_empty_zero, m_axis_tvalid && m_axis_tuser == ST_EMPTY,
                   m_axis_tdata[88:0] == '0)

endmodule

`default_nettype wire
